/* rtl/ledmfs_pkg.sv */
// ----------------------------------------------------------------------------
// ledmfs_pkg: shared types and constants of the LED matrix frame serializer
// Holds the request and result structs, the request and register codes, the
// frame store geometry and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
package ledmfs_pkg;

   // Matrix geometry.
   localparam int COLUMNS = 8;
   localparam int ROWS    = 8;
   localparam int PIXELS  = COLUMNS * ROWS;
   localparam int PIX_W   = (PIXELS > 1) ? $clog2(PIXELS) : 1;

   // Request codes.
   localparam logic [2:0] REQ_SET_PIXEL = 3'd0;
   localparam logic [2:0] REQ_PIXEL_OFF = 3'd1;
   localparam logic [2:0] REQ_CLEAR_ALL = 3'd2;
   localparam logic [2:0] REQ_START     = 3'd3;
   localparam logic [2:0] REQ_TICK      = 3'd4;

   // Register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD     = 2'd3;

   typedef struct packed {
      logic [2:0] req_type;
      logic [2:0] col;
      logic [2:0] row;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type_type;

   typedef struct packed {
      logic data_line;
      logic busy_res;
      logic rejected;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
      logic load_rsp;
   } ctl_cmd_type;

endpackage

/* rtl/ledmfs_ctrl.sv */
// ----------------------------------------------------------------------------
// ledmfs_ctrl: sequencing state machine
// Accepts one request, runs it through the datapath and hands the result to
// the output register, which is emptied independently by the consumer.
// ----------------------------------------------------------------------------
module ledmfs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ledmfs_pkg::ctl_cmd_type  cmd
);
   import ledmfs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_POST = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.capture  = (state_ff == ST_IDLE) && req_valid;
      cmd.execute  = (state_ff == ST_EXEC);
      cmd.load_rsp = (state_ff == ST_POST) && rsp_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_POST;
         end
         ST_POST: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/ledmfs_datapath.sv */
// ----------------------------------------------------------------------------
// ledmfs_datapath: frame store, bit timing counters and registers
// One memory word holds one pixel as green, red, blue. A valid bit per pixel
// makes unwritten or cleared pixels read as zero.
// ----------------------------------------------------------------------------
module ledmfs_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ledmfs_pkg::ctl_cmd_type                 cmd,
   input  ledmfs_pkg::req_type_type                req_data,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [ledmfs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [7:0]                              csr_data,
   output ledmfs_pkg::rsp_type                     rsp_data
);
   import ledmfs_pkg::*;

   localparam logic [1:0] CHAN_GREEN = 2'd0;
   localparam logic [1:0] CHAN_RED   = 2'd1;
   localparam logic [1:0] CHAN_BLUE  = 2'd2;

   // Configuration registers.
   logic [7:0] brightness_ff;
   logic [5:0] zero_high_ff, one_high_ff, period_ff;

   // Captured request.
   req_type_type item_ff;

   // Frame store and its read port.
   logic [23:0]       store_mem [PIXELS];
   logic [PIXELS-1:0] valid_ff, valid_in;
   logic [23:0]       rd_ff;
   logic              rdv_ff;

   // Serializer state.
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [1:0]       chan_ff, chan_in;
   logic [2:0]       bit_ff, bit_in;
   logic [5:0]       tick_ff, tick_in;
   logic             sending_ff, sending_in;
   logic             line_ff, line_in;

   rsp_type res_ff, res_in;
   rsp_type rsp_ff;

   logic             is_tick, is_cmd, in_range, rej;
   logic [PIX_W-1:0] wr_addr;
   logic [15:0]      prod_r, prod_g, prod_b;
   logic [7:0]       sc_r, sc_g, sc_b;
   logic             wr_en;
   logic [23:0]      cur_word;
   logic [7:0]       cur_byte;
   logic [5:0]       high_len, tick_inc;
   logic             bit_end;

   assign is_tick  = (item_ff.req_type == REQ_TICK);
   assign is_cmd   = item_ff.req_type inside {REQ_SET_PIXEL, REQ_PIXEL_OFF,
                                              REQ_CLEAR_ALL, REQ_START};
   assign rej      = is_cmd && sending_ff;
   assign in_range = (int'(item_ff.col) < COLUMNS) && (int'(item_ff.row) < ROWS);
   assign wr_addr  = PIX_W'(int'(item_ff.col) * ROWS + int'(item_ff.row));

   assign prod_r = item_ff.red   * brightness_ff;
   assign prod_g = item_ff.green * brightness_ff;
   assign prod_b = item_ff.blue  * brightness_ff;
   assign sc_r   = (brightness_ff == 8'd0) ? item_ff.red   : prod_r[15:8];
   assign sc_g   = (brightness_ff == 8'd0) ? item_ff.green : prod_g[15:8];
   assign sc_b   = (brightness_ff == 8'd0) ? item_ff.blue  : prod_b[15:8];

   assign wr_en = cmd.execute && !rej && in_range &&
                  (item_ff.req_type == REQ_SET_PIXEL);

   // Current byte and bit of the frame being sent.
   assign cur_word = rdv_ff ? rd_ff : 24'd0;
   always_comb begin
      case (chan_ff)
         CHAN_GREEN: cur_byte = cur_word[23:16];
         CHAN_RED:   cur_byte = cur_word[15:8];
         CHAN_BLUE:  cur_byte = cur_word[7:0];
         default:    cur_byte = cur_word[7:0];
      endcase
   end

   assign high_len = cur_byte[bit_ff] ? one_high_ff : zero_high_ff;
   assign tick_inc = tick_ff + 6'd1;
   assign bit_end  = (tick_inc >= period_ff) || (tick_inc == 6'd0);

   always_comb begin
      valid_in   = valid_ff;
      pix_in     = pix_ff;
      chan_in    = chan_ff;
      bit_in     = bit_ff;
      tick_in    = tick_ff;
      sending_in = sending_ff;
      line_in    = line_ff;
      if (cmd.execute) begin
         if (is_tick) begin
            if (sending_ff) begin
               line_in = (tick_ff < high_len);
               tick_in = tick_inc;
               if (bit_end) begin
                  tick_in = 6'd0;
                  if (bit_ff == 3'd0) begin
                     bit_in = 3'd7;
                     if (chan_ff == CHAN_BLUE) begin
                        chan_in = CHAN_GREEN;
                        if (pix_ff == PIX_W'(PIXELS - 1)) begin
                           pix_in     = '0;
                           sending_in = 1'b0;
                           line_in    = 1'b0;
                        end else begin
                           pix_in = pix_ff + PIX_W'(1);
                        end
                     end else begin
                        chan_in = chan_ff + 2'd1;
                     end
                  end else begin
                     bit_in = bit_ff - 3'd1;
                  end
               end
            end
         end else if (!rej) begin
            case (item_ff.req_type)
               REQ_SET_PIXEL: begin
                  if (in_range) valid_in[wr_addr] = 1'b1;
               end
               REQ_PIXEL_OFF: begin
                  if (in_range) valid_in[wr_addr] = 1'b0;
               end
               REQ_CLEAR_ALL: begin
                  valid_in = '0;
               end
               REQ_START: begin
                  sending_in = 1'b1;
                  pix_in     = '0;
                  chan_in    = CHAN_GREEN;
                  bit_in     = 3'd7;
                  tick_in    = 6'd0;
                  line_in    = 1'b0;
               end
               default: begin
                  // Unknown request codes change nothing.
               end
            endcase
         end
      end
   end

   always_comb begin
      res_in = res_ff;
      if (cmd.execute) begin
         res_in.data_line = line_in;
         res_in.busy_res  = sending_in;
         res_in.rejected  = rej;
      end
   end

   // Frame store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= {sc_g, sc_r, sc_b};
      end
      rd_ff  <= store_mem[pix_ff];
      rdv_ff <= valid_ff[pix_ff];
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_data;
      res_ff <= res_in;
      if (cmd.load_rsp) rsp_ff <= res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         pix_ff        <= '0;
         chan_ff       <= CHAN_GREEN;
         bit_ff        <= 3'd7;
         tick_ff       <= 6'd0;
         sending_ff    <= 1'b0;
         line_ff       <= 1'b0;
         brightness_ff <= 8'd0;
         zero_high_ff  <= 6'd5;
         one_high_ff   <= 6'd13;
         period_ff     <= 6'd20;
      end else begin
         valid_ff   <= valid_in;
         pix_ff     <= pix_in;
         chan_ff    <= chan_in;
         bit_ff     <= bit_in;
         tick_ff    <= tick_in;
         sending_ff <= sending_in;
         line_ff    <= line_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BRIGHTNESS: brightness_ff <= csr_data;
               CSR_ZERO_HIGH:  zero_high_ff  <= csr_data[5:0];
               CSR_ONE_HIGH:   one_high_ff   <= csr_data[5:0];
               CSR_PERIOD:     period_ff     <= csr_data[5:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* rtl/led_matrix_frame_serializer.sv */
// ----------------------------------------------------------------------------
// led_matrix_frame_serializer: one-wire serial driver for an RGB LED matrix
// Keeps a frame of pixels, takes pixel, clear and start commands, and turns
// each tick request into one clock of the serial line waveform.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                               Transfer when
//   -------   ---------------------------------   ---------------------------
//   request   req_valid, req_stall, req_data      req_valid && !req_stall
//   result    rsp_valid, rsp_stall, rsp_data      rsp_valid && !rsp_stall
//   config    csr_valid, csr_ready, csr_index,    csr_valid && csr_ready
//             csr_data
//
// Every request passes through the three controller states: capture (with
// the frame store read), execute, which updates the store and serializer
// state, and hand-off, which moves the result into the output register.
// Each request gives exactly one result.
// Reset is synchronous; it clears the pixel valid bits at once, so the whole
// frame store reads as dark right after reset, with no clearing pass.
// A stalled result waits in the output register while the next request is
// accepted and executed. The request side is stalled in every execute and
// hand-off cycle, and the hand-off cycle repeats for as long as the output
// register is still full and its result stalled.
// Configuration writes are always taken and act on the next request.
//
module led_matrix_frame_serializer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ledmfs_pkg::req_type_type           req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ledmfs_pkg::rsp_type                rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ledmfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                         csr_data
);
   import ledmfs_pkg::*;

   ctl_cmd_type cmd;

   // Registers are plain flip-flops, so a write can always complete.
   assign csr_ready = 1'b1;

   // The controller decides when a request is captured, executed and
   // handed to the output register.
   ledmfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // The datapath holds the frame store, the bit timing counters and the
   // configuration registers.
   ledmfs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/ledmfs_checker.sv */
// ----------------------------------------------------------------------------
// ledmfs_checker: port-level checks of the LED matrix frame serializer
// Watches the result channel for handshake and frame-state consistency.
// ----------------------------------------------------------------------------
module ledmfs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input ledmfs_pkg::rsp_type       rsp_data
);
   import ledmfs_pkg::*;

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result does not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result changed while stalled");

   // A command can only be turned away while a frame is still being sent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rejected |-> rsp_data.busy_res)
      else $error("rejection reported while idle");

   // The line is low whenever no frame is being sent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.busy_res |-> !rsp_data.data_line)
      else $error("line high while idle");

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind led_matrix_frame_serializer ledmfs_checker u_ledmfs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for led_matrix_frame_serializer
// Drives pixel, clear, start and tick requests and programs the brightness and
// bit timing registers between phases, also in the middle of a frame. An
// in-bench model of the frame store and the bit serializer predicts every
// result, and each result is compared field by field. Random sender gaps and
// result stalls cover the handshakes.
// ----------------------------------------------------------------------------
module testbench;
   import ledmfs_pkg::*;

   localparam int         STORE_BYTES        = PIXELS * 3;
   localparam int         WATCHDOG_LIMIT     = 1000;
   localparam int         DRAIN_CYCLES       = 20;
   localparam int         PIXEL_COMMANDS     = 32;
   localparam int         SEGMENT_BITS       = 6;
   localparam int         TIMING_SEGMENTS    = 6;
   localparam int         MID_BIT_TICKS      = 20;
   localparam int         FULL_RATE_COMMANDS = 24;
   localparam logic [2:0] REQ_UNUSED_FIRST   = REQ_TICK + 3'd1;
   localparam logic [2:0] REQ_UNUSED_LAST    = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type_type         req_data;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0]           csr_data;

   // Shadow of the block: frame store, serializer position and registers.
   logic [7:0] shadow_store [STORE_BYTES];
   int         byte_ptr;
   logic [2:0] bit_ptr;
   logic [5:0] tick_cnt;
   logic       frame_active;
   logic       line_now;
   logic [7:0] bright;
   logic [5:0] zero_high;
   logic [5:0] one_high;
   logic [5:0] period;

   // Line results predicted for accepted requests, oldest first.
   rsp_type line_expect [$];
   rsp_type want;

   int err_count      = 0;
   int results_seen   = 0;
   int items_sent     = 0;
   int frames_started = 0;
   int refusals       = 0;
   int quiet_cycles   = 0;
   int stall_left     = 0;
   bit sender_gaps;
   bit receiver_stalls;

   led_matrix_frame_serializer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   function void reset_shadow();
      foreach (shadow_store[i]) shadow_store[i] = 8'd0;
      byte_ptr     = 0;
      bit_ptr      = 3'd7;
      tick_cnt     = 6'd0;
      frame_active = 1'b0;
      line_now     = 1'b0;
      bright       = 8'd0;
      zero_high    = 6'd5;
      one_high     = 6'd13;
      period       = 6'd20;
   endfunction

   // A nonzero brightness scales a channel by brightness/256, rounding down.
   function automatic logic [7:0] dim(input logic [7:0] level);
      logic [15:0] prod;
      prod = level * bright;
      return (bright == 8'd0) ? level : prod[15:8];
   endfunction

   // One clock of the line waveform. The line is high while the tick count
   // is below the high time of the current bit. The tick counter wraps at six
   // bits, so a period of zero or one ends every bit after a single tick.
   function void advance_line();
      logic [7:0] cur;
      logic [5:0] high_len;
      cur      = shadow_store[byte_ptr];
      high_len = cur[bit_ptr] ? one_high : zero_high;
      line_now = (tick_cnt < high_len);
      tick_cnt = tick_cnt + 6'd1;
      if (tick_cnt >= period || tick_cnt == 6'd0) begin
         tick_cnt = 6'd0;
         if (bit_ptr == 3'd0) begin
            bit_ptr = 3'd7;
            byte_ptr++;
            if (byte_ptr >= STORE_BYTES) begin
               // The last bit of the frame is done: the line returns low.
               byte_ptr     = 0;
               frame_active = 1'b0;
               line_now     = 1'b0;
            end
         end else begin
            bit_ptr--;
         end
      end
   endfunction

   // Number of bits of the current frame that are fully sent.
   function automatic int bits_sent();
      return byte_ptr * 8 + (7 - int'(bit_ptr));
   endfunction

   function automatic rsp_type predict_line(input req_type_type r);
      rsp_type res;
      int      base;
      res.rejected = 1'b0;
      base = (int'(r.col) * ROWS + int'(r.row)) * 3;
      if (r.req_type == REQ_TICK) begin
         if (frame_active) advance_line();
      end else if (r.req_type <= REQ_START && frame_active) begin
         res.rejected = 1'b1;
         refusals++;
      end else begin
         case (r.req_type)
            REQ_SET_PIXEL: begin
               if (r.col < COLUMNS && r.row < ROWS) begin
                  shadow_store[base]     = dim(r.green);
                  shadow_store[base + 1] = dim(r.red);
                  shadow_store[base + 2] = dim(r.blue);
               end
            end
            REQ_PIXEL_OFF: begin
               if (r.col < COLUMNS && r.row < ROWS) begin
                  shadow_store[base]     = 8'd0;
                  shadow_store[base + 1] = 8'd0;
                  shadow_store[base + 2] = 8'd0;
               end
            end
            REQ_CLEAR_ALL: begin
               foreach (shadow_store[i]) shadow_store[i] = 8'd0;
            end
            REQ_START: begin
               frame_active = 1'b1;
               byte_ptr     = 0;
               bit_ptr      = 3'd7;
               tick_cnt     = 6'd0;
               line_now     = 1'b0;
               frames_started++;
            end
            default: begin
               // Unused request codes change nothing, busy or not.
            end
         endcase
      end
      res.data_line = line_now;
      res.busy_res  = frame_active;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Request builders
   // ------------------------------------------------------------------------

   function automatic req_type_type make_req(input logic [2:0] code,
                                             input logic [2:0] col, row,
                                             input logic [7:0] red, green, blue);
      req_type_type r;
      r.req_type = code;
      r.col      = col;
      r.row      = row;
      r.red      = red;
      r.green    = green;
      r.blue     = blue;
      return r;
   endfunction

   // Channel levels lean toward the extremes so that full scale and dark
   // both show up often in the serialized bytes.
   function automatic logic [7:0] rand_level();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 8'd0;
      if (pick == 1) return 8'd255;
      return 8'($urandom);
   endfunction

   // Brightness leans toward no scaling and full scale.
   function automatic logic [7:0] rand_bright();
      int pick;
      pick = $urandom_range(0, 7);
      return (pick < 2) ? 8'd0 : (pick == 2) ? 8'd255 : 8'($urandom);
   endfunction

   function automatic req_type_type rand_pixel();
      return make_req(REQ_SET_PIXEL, 3'($urandom), 3'($urandom),
                      rand_level(), rand_level(), rand_level());
   endfunction

   // Mostly pixel writes, so that frames carry varied data, with some pixel
   // off, idle ticks, unused codes, rare clears and rarer frame starts.
   function automatic req_type_type random_command();
      req_type_type r;
      int           pick;
      r    = rand_pixel();
      pick = $urandom_range(0, 199);
      if (pick < 110)      r.req_type = REQ_SET_PIXEL;
      else if (pick < 140) r.req_type = REQ_PIXEL_OFF;
      else if (pick < 165) r.req_type = REQ_TICK;
      else if (pick < 192) r.req_type = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
      else if (pick < 198) r.req_type = REQ_CLEAR_ALL;
      else                 r.req_type = REQ_START;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Sends one request and records its predicted result once the transfer
   // happens. Entered and left at a falling edge; valid stays high on return
   // so that back-to-back requests need no extra cycle.
   task automatic send_req(input req_type_type r);
      if (sender_gaps && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      line_expect.push_back(predict_line(r));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_tick();
      req_type_type r;
      r = rand_pixel();
      r.req_type = REQ_TICK;
      send_req(r);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_BRIGHTNESS: bright    = value;
         CSR_ZERO_HIGH:  zero_high = value[5:0];
         CSR_ONE_HIGH:   one_high  = value[5:0];
         CSR_PERIOD:     period    = value[5:0];
         default:        ;
      endcase
      @(negedge clock);
   endtask

   // Registers change only with the block idle: every request has been
   // taken and its result has come back. The timing registers are six bits
   // wide, so the upper bits of the data are dropped.
   task automatic program_regs(input logic [7:0] b, z, o, p);
      req_valid <= 1'b0;
      while (line_expect.size() != 0) @(posedge clock);
      @(negedge clock);
      write_reg(CSR_BRIGHTNESS, b);
      write_reg(CSR_ZERO_HIGH, z);
      write_reg(CSR_ONE_HIGH, o);
      write_reg(CSR_PERIOD, p);
      csr_valid <= 1'b0;
   endtask

   // Short periods and high times that fall below, at or beyond the period,
   // with random upper bits in the register data.
   task automatic program_random_timing(input logic [7:0] b);
      logic [5:0] z, o, p;
      p = 6'($urandom_range(0, 4));
      z = ($urandom_range(0, 7) == 0) ? 6'd63 : 6'($urandom_range(0, 6));
      o = ($urandom_range(0, 7) == 0) ? 6'd63 : 6'($urandom_range(0, 6));
      program_regs(b, {2'($urandom), z}, {2'($urandom), o}, {2'($urandom), p});
   endtask

   // Ticks the current frame until the given number of further bits is sent
   // or the frame ends. Other commands are mixed in at the given percentage;
   // all but ticks and the unused codes must be refused.
   task automatic tick_bits(input int count, input int noise_pct);
      req_type_type r;
      int           target;
      target = bits_sent() + count;
      while (frame_active && bits_sent() < target) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            r = random_command();
         end else begin
            r = rand_pixel();
            r.req_type = REQ_TICK;
         end
         send_req(r);
      end
   endtask

   // Ticks the current frame out to its end.
   task automatic finish_frame(input int noise_pct);
      tick_bits(STORE_BYTES * 8, noise_pct);
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   // Result stalls come in bursts of random length while receiver stalls are enabled.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (line_expect.size() == 0) begin
            $error("result with no request outstanding: %p", rsp_data);
            err_count++;
         end else begin
            want = line_expect.pop_front();
            results_seen++;
            if (rsp_data.data_line !== want.data_line) begin
               $error("data_line mismatch: expected %0b, got %0b",
                      want.data_line, rsp_data.data_line);
               err_count++;
            end
            if (rsp_data.busy_res !== want.busy_res) begin
               $error("busy_res mismatch: expected %0b, got %0b",
                      want.busy_res, rsp_data.busy_res);
               err_count++;
            end
            if (rsp_data.rejected !== want.rejected) begin
               $error("rejected mismatch: expected %0b, got %0b",
                      want.rejected, rsp_data.rejected);
               err_count++;
            end
         end
      end
   end

   // Watchdog: a long run of cycles with no transfer on any channel means
   // the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $error("no transfer for %0d cycles, %0d results outstanding",
                WATCHDOG_LIMIT, line_expect.size());
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Right after reset nothing is being sent: ticks keep the line low, the
   // unused codes do nothing, and pixel off and clear are accepted quietly.
   task automatic test_idle_requests();
      req_type_type r;
      r = rand_pixel();
      r.req_type = REQ_TICK;
      send_req(r);
      send_req(r);
      for (int c = REQ_UNUSED_FIRST; c <= REQ_UNUSED_LAST; c++) begin
         r.req_type = 3'(c);
         send_req(r);
      end
      send_req(make_req(REQ_PIXEL_OFF, 3'(COLUMNS - 1), 3'(ROWS - 1), 8'd0, 8'd0, 8'd0));
      send_req(make_req(REQ_CLEAR_ALL, 3'd0, 3'd0, 8'd0, 8'd0, 8'd0));
   endtask

   // Pixels are written under no scaling, full scale and the smallest scale,
   // then random commands fill the store under a random scale. The timing is
   // set to one-tick bits with a zero high time for zero bits.
   task automatic test_pixel_writes();
      req_type_type r;
      program_regs(8'd0, 8'd0, 8'd1, 8'd1);
      send_req(make_req(REQ_SET_PIXEL, 3'd0, 3'd0, 8'd255, 8'd255, 8'd255));
      send_req(make_req(REQ_SET_PIXEL, 3'd7, 3'd7, 8'hA5, 8'h00, 8'h5A));
      send_req(make_req(REQ_SET_PIXEL, 3'd1, 3'd1, 8'd255, 8'd255, 8'd255));
      send_req(make_req(REQ_PIXEL_OFF, 3'd1, 3'd1, 8'd0, 8'd0, 8'd0));
      program_regs(8'd255, 8'd0, 8'd1, 8'd1);
      send_req(make_req(REQ_SET_PIXEL, 3'd0, 3'd7, 8'd255, 8'd128, 8'd1));
      send_req(make_req(REQ_SET_PIXEL, 3'd3, 3'd4, 8'h81, 8'h7E, 8'hC3));
      program_regs(8'd1, 8'd0, 8'd1, 8'd1);
      send_req(make_req(REQ_SET_PIXEL, 3'd5, 3'd5, 8'd255, 8'd255, 8'd255));
      program_regs(rand_bright(), 8'd0, 8'd1, 8'd1);
      repeat (PIXEL_COMMANDS) begin
         r = random_command();
         // The frame is started by the frame tests only.
         if (r.req_type == REQ_START) r.req_type = REQ_SET_PIXEL;
         send_req(r);
      end
   endtask

   // A frame is started. While it runs every command kind is tried once:
   // all are refused except the unused code.
   task automatic test_busy_refusals();
      send_req(make_req(REQ_START, 3'd0, 3'd0, 8'd0, 8'd0, 8'd0));
      send_req(make_req(REQ_START, 3'd0, 3'd0, 8'd0, 8'd0, 8'd0));
      send_req(make_req(REQ_SET_PIXEL, 3'd2, 3'd2, 8'd255, 8'd255, 8'd255));
      send_req(make_req(REQ_PIXEL_OFF, 3'd0, 3'd0, 8'd0, 8'd0, 8'd0));
      send_req(make_req(REQ_CLEAR_ALL, 3'd0, 3'd0, 8'd0, 8'd0, 8'd0));
      send_req(make_req(REQ_UNUSED_LAST, 3'd0, 3'd0, 8'd0, 8'd0, 8'd0));
      tick_bits(SEGMENT_BITS, 0);
   endtask

   // Register data with the upper bits set: the period truncates to zero, a
   // zero bit stays high for the whole bit and a one bit stays low.
   task automatic test_truncated_timing();
      program_regs(bright, 8'hFF, 8'hC0, 8'h40);
      tick_bits(SEGMENT_BITS, 10);
   endtask

   // The longest bit: a period of 63 with a one-bit high time equal to it.
   // The next bit is left partway through, so the settings that follow take
   // effect in the middle of a bit.
   task automatic test_longest_bits();
      program_regs(bright, 8'd1, 8'd63, 8'd63);
      tick_bits(1, 1);
      repeat (MID_BIT_TICKS) send_tick();
   endtask

   // Random timing settings change every few bits of the running frame.
   task automatic test_random_timing();
      repeat (TIMING_SEGMENTS) begin
         program_random_timing(bright);
         tick_bits(SEGMENT_BITS, 5);
      end
   endtask

   // The rest of the frame goes out with one-tick bits, so the line follows
   // the data, and the frame end returns the line low and clears busy.
   task automatic test_frame_end();
      program_regs(bright, 8'd0, 8'd1, 8'd1);
      finish_frame(1);
   endtask

   // The last part runs at full rate on both sides: random commands on an
   // idle block, then a new frame that is still running when the run ends.
   task automatic test_full_rate();
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      program_random_timing(rand_bright());
      repeat (FULL_RATE_COMMANDS) send_req(random_command());
      send_req(make_req(REQ_START, 3'd0, 3'd0, 8'd0, 8'd0, 8'd0));
      tick_bits(SEGMENT_BITS, 5);
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      reset_shadow();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_requests();
      test_pixel_writes();
      test_busy_refusals();
      test_truncated_timing();
      test_longest_bits();
      test_random_timing();
      test_frame_end();
      test_full_rate();

      // Let the last results come back, then give the block a few more
      // cycles to show any result it should not produce.
      req_valid <= 1'b0;
      while (line_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results for %0d requests over %0d frames;",
               results_seen, items_sent, frames_started);
      $display("%0d commands were refused while a frame was being sent.", refusals);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
